// ===== rtl/fas_pkg.sv =====
`default_nettype none
package fas_pkg;

  localparam logic [31:0] HIDDEN_ONE = 32'h4000_0000;
  localparam logic [7:0]  EXP_BIAS   = 8'd127;
  localparam logic        FUNC_ADD   = 1'b0;
  localparam logic        FUNC_SUB   = 1'b1;

  // Unpacked operand pair after stage one.
  typedef struct packed {
    logic signed [9:0]  exp_a;
    logic signed [9:0]  exp_b;
    logic signed [31:0] frac_a;
    logic signed [31:0] frac_b;
  } unp_t;

  // Aligned and summed value after stage two.
  typedef struct packed {
    logic signed [9:0]  exp;
    logic               neg;
    logic               zero;
    logic [31:0]        mag;
  } sum_t;

  // Signed fraction with the hidden one at bit 30, or zero.
  function automatic logic signed [31:0] unpack_frac(input logic [31:0] bits);
    logic [31:0] f;
    f = HIDDEN_ONE | {2'b00, bits[22:0], 7'b0};
    if (bits[30:0] == 31'd0) return 32'sd0;
    return bits[31] ? -$signed(f) : $signed(f);
  endfunction

  function automatic logic signed [9:0] unpack_exp(input logic [31:0] bits);
    if (bits[30:0] == 31'd0) return 10'sd0;
    return $signed({2'b00, bits[30:23]}) - $signed({2'b00, EXP_BIAS});
  endfunction

endpackage
`default_nettype wire

// ===== rtl/fas_align.sv =====
`default_nettype none
module fas_align (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          vld_i,
  input  wire fas_pkg::unp_t unp_i,
  output logic               vld_o,
  output fas_pkg::sum_t      sum_o
);
  import fas_pkg::*;

  logic signed [10:0] diff;
  logic [4:0]         sh;
  logic signed [31:0] fa, fb;
  logic signed [9:0]  ex;
  logic signed [32:0] total;
  logic               vld_r;
  sum_t               sum_r, sum_nxt;

  // Align the smaller-exponent fraction, halve both and add.
  always_comb begin
    diff = 11'(unp_i.exp_a) - 11'(unp_i.exp_b);
    fa = unp_i.frac_a;
    fb = unp_i.frac_b;
    ex = unp_i.exp_a;
    sh = 5'd0;
    if (diff > 0) begin
      sh = (diff > 11'sd31) ? 5'd31 : diff[4:0];
      fb = fb >>> sh;
    end else if (diff < 0) begin
      sh = (-diff > 11'sd31) ? 5'd31 : 5'(-diff);
      fa = fa >>> sh;
      ex = unp_i.exp_b;
    end
    total = 33'(fa >>> 1) + 33'(fb >>> 1);
    sum_nxt.exp  = ex + 10'sd1;
    sum_nxt.neg  = total[32];
    sum_nxt.zero = (total == 33'sd0);
    sum_nxt.mag  = total[32] ? 32'(-total) : total[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
    sum_r <= sum_nxt;
  end

  assign vld_o = vld_r;
  assign sum_o = sum_r;
endmodule
`default_nettype wire

// ===== rtl/fas_norm.sv =====
`default_nettype none
module fas_norm (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          vld_i,
  input  wire fas_pkg::sum_t sum_i,
  output logic               vld_o,
  output logic [31:0]        res_o
);
  import fas_pkg::*;

  logic [4:0]  lz;
  logic [31:0] mag;
  logic [9:0]  ex;
  logic        vld_r;
  logic [31:0] res_r, res_nxt;

  // Count leading zeros below bit 30, shift up and pack with truncation.
  always_comb begin
    lz = 5'd0;
    for (int i = 0; i <= 30; i++) begin
      if (sum_i.mag[i]) lz = 5'(30 - i);
    end
    mag = sum_i.mag << lz;
    ex  = 10'(sum_i.exp) - 10'(lz) + 10'(EXP_BIAS);
    if (sum_i.zero) begin
      res_nxt = 32'd0;
    end else begin
      res_nxt = {sum_i.neg, ex[7:0], mag[29:7]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
    res_r <= res_nxt;
  end

  assign vld_o = vld_r;
  assign res_o = res_r;
endmodule
`default_nettype wire

// ===== rtl/float32_add_sub_truncating_top.sv =====
// Single-precision adder/subtractor with truncation, three register stages.
// A start beat is registered in the unpack, align-and-add and normalize stages in turn before its result strobes.
// Throughput: one beat per cycle; busy is always low.
// Stages: unpack, align and add, normalize and pack.
// Reset (rst_n low, synchronous) clears all valid bits; the receiver cannot stall.
`default_nettype none
module float32_add_sub_truncating_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] in_operand_a,
  input  wire logic [31:0] in_operand_b,
  input  wire logic        in_func,
  output logic             out_valid,
  output logic [31:0]      out_result
);
  import fas_pkg::*;

  logic        vld_r;
  unp_t        unp_r, unp_nxt;
  logic [31:0] b_eff;
  logic        vld2;
  sum_t        sum2;

  assign busy = 1'b0;

  // Stage one: apply the operation and unpack both operands.
  always_comb begin
    b_eff = in_operand_b;
    if (in_func == FUNC_SUB) b_eff[31] = ~in_operand_b[31];
    unp_nxt.exp_a  = unpack_exp(in_operand_a);
    unp_nxt.exp_b  = unpack_exp(b_eff);
    unp_nxt.frac_a = unpack_frac(in_operand_a);
    unp_nxt.frac_b = unpack_frac(b_eff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= start;
    end
    unp_r <= unp_nxt;
  end

  fas_align u_align (
    .clk(clk), .rst_n(rst_n), .vld_i(vld_r), .unp_i(unp_r),
    .vld_o(vld2), .sum_o(sum2)
  );

  fas_norm u_norm (
    .clk(clk), .rst_n(rst_n), .vld_i(vld2), .sum_i(sum2),
    .vld_o(out_valid), .res_o(out_result)
  );
endmodule
`default_nettype wire

// ===== verif/tb_float32_add_sub_truncating_top.sv =====
`timescale 1ns / 1ps
module tb_float32_add_sub_truncating_top;
  import fas_pkg::*;

  localparam int NUM_RANDOM   = 1630;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 10;
  localparam logic [31:0] SIGN_MASK = 32'h8000_0000;

  // Scoreboard: predicts the truncated sum for each accepted beat and checks results.
  class fp_sum_board;
    logic [31:0] pending_sums[$];
    int mismatches;

    // Arithmetic right shift that rounds toward minus infinity.
    function automatic longint asr(longint x, int n);
      return x >>> n;
    endfunction

    function automatic logic [31:0] predict_sum(logic [31:0] a, logic [31:0] b);
      int ea, eb, gap, ex;
      longint fa, fb, total;
      logic [31:0] mag, packed_sum;
      logic neg;
      ea = (a[30:0] == 0) ? 0 : int'(a[30:23]) - 127;
      eb = (b[30:0] == 0) ? 0 : int'(b[30:23]) - 127;
      fa = (a[30:0] == 0) ? 0 : longint'({2'b01, a[22:0], 7'b0});
      fb = (b[30:0] == 0) ? 0 : longint'({2'b01, b[22:0], 7'b0});
      if (a[31]) fa = -fa;
      if (b[31]) fb = -fb;
      gap = ea - eb;
      if (gap > 0) begin
        fb = asr(fb, (gap > 31) ? 31 : gap);
        ex = ea;
      end else if (gap < 0) begin
        fa = asr(fa, (-gap > 31) ? 31 : -gap);
        ex = eb;
      end else begin
        ex = ea;
      end
      total = asr(fa, 1) + asr(fb, 1);
      ex = ex + 1;
      if (total == 0) return 32'h0;
      neg = total < 0;
      mag = neg ? 32'(-total) : 32'(total);
      while (mag[30] == 1'b0) begin
        mag = mag << 1;
        ex = ex - 1;
      end
      packed_sum = {neg, 8'(ex + 127), mag[29:7]};
      return packed_sum;
    endfunction

    function void note_beat(logic [31:0] a, logic [31:0] b, logic func);
      logic [31:0] b_eff;
      b_eff = (func == FUNC_SUB) ? (b ^ SIGN_MASK) : b;
      pending_sums.push_back(predict_sum(a, b_eff));
    endfunction

    function void check_result(logic [31:0] got);
      logic [31:0] want;
      if (pending_sums.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result %h", got);
        return;
      end
      want = pending_sums.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: result expected %h got %h", want, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [31:0] in_operand_a = '0;
  logic [31:0] in_operand_b = '0;
  logic in_func = FUNC_ADD;
  logic busy, out_valid;
  logic [31:0] out_result;

  fp_sum_board board = new();
  int idle_cycles = 0;
  bit idle_enable = 1'b1;

  always #5 clk = ~clk;

  float32_add_sub_truncating_top u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operand_a(in_operand_a), .in_operand_b(in_operand_b), .in_func(in_func),
    .out_valid(out_valid), .out_result(out_result)
  );

  // Sample both channels at the rising edge and run the stall watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) board.note_beat(in_operand_a, in_operand_b, in_func);
      if (out_valid) board.check_result(out_result);
      if ((start && !busy) || out_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Drive one beat, holding start until it is accepted.
  task automatic send_beat(logic [31:0] a, logic [31:0] b, logic func);
    int gap;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_operand_a <= a;
    in_operand_b <= b;
    in_func <= func;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Random operand with a bias toward zeros, close exponents and edge fields.
  function automatic logic [31:0] rand_operand(logic [7:0] near_exp);
    logic [31:0] v;
    v = $urandom();
    case ($urandom_range(0, 9))
      0: v[30:0] = '0;
      1, 2, 3, 4: v[30:23] = near_exp + 8'($urandom_range(0, 6)) - 8'd3;
      5: v[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: ;
    endcase
    return v;
  endfunction

  initial begin
    logic [31:0] a;
    logic [7:0] e;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: zeros, equal and opposite values, extremes, wrap and huge gaps.
    send_beat(32'h0000_0000, 32'h0000_0000, FUNC_ADD);
    send_beat(32'h8000_0000, 32'h0000_0000, FUNC_SUB);
    send_beat(32'h3F80_0000, 32'h3F80_0000, FUNC_ADD);
    send_beat(32'h3F80_0000, 32'h3F80_0000, FUNC_SUB);
    send_beat(32'h3F80_0000, 32'hBF80_0000, FUNC_ADD);
    send_beat(32'h4000_0000, 32'h3F80_0000, FUNC_SUB);
    send_beat(32'h7F7F_FFFF, 32'h7F7F_FFFF, FUNC_ADD);
    send_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF, FUNC_ADD);
    send_beat(32'h0000_0001, 32'h0000_0000, FUNC_ADD);
    send_beat(32'h0080_0000, 32'h8080_0000, FUNC_SUB);
    send_beat(32'h7F80_0000, 32'h0000_0001, FUNC_ADD);
    send_beat(32'h7F80_0000, 32'h0000_0001, FUNC_SUB);
    send_beat(32'h3F80_0000, 32'hB3FF_FFFF, FUNC_ADD);
    send_beat(32'hBF80_0000, 32'h3380_0000, FUNC_SUB);
    send_beat(32'h0000_0000, 32'h3000_0000, FUNC_ADD);
    send_beat(32'h0000_0000, 32'hB000_0000, FUNC_SUB);
    send_beat(32'h3FFF_FFFF, 32'h3F80_0001, FUNC_SUB);
    send_beat(32'hAAAA_AAAA, 32'h5555_5555, FUNC_ADD);
    send_beat(32'h5555_5555, 32'hAAAA_AAAA, FUNC_SUB);

    // Hold off until every expected result has arrived.
    start <= 1'b0;
    while (board.pending_sums.size() != 0) @(negedge clk);

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i > NUM_RANDOM - 200) idle_enable = 1'b0;
      e = 8'($urandom());
      a = rand_operand(e);
      send_beat(a, rand_operand(e), 1'($urandom()));
    end
    start <= 1'b0;

    while (board.pending_sums.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (board.mismatches == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
